### src/skct_pkg.sv
package skct_pkg;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] key;
      logic [15:0] increment;
      logic [7:0]  index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  position;
      logic [31:0] entry_key;
      logic [31:0] entry_count;
      logic        was_inserted;
      logic [8:0]  entries_used;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_COMPARE,
      ST_UPDATE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_READ_DONE
   } state_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_UPDATE,
      RES_INSERT,
      RES_READ,
      RES_FULL,
      RES_RANGE,
      RES_CLEAR,
      RES_NOP
   } res_type;

   typedef struct packed {
      logic    capture;
      logic    search_rd;
      logic    search_step;
      logic    shift_rd;
      logic    shift_wr;
      logic    read_rd;
      res_type result;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       lo_lt_hi;
      logic       key_lt;
      logic       key_eq;
      logic       table_full;
      logic       shift_more;
      logic       read_ok;
   } stat_type;

endpackage

### src/skct_datapath.sv
module skct_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  skct_pkg::req_type req_item,
   input  skct_pkg::cmd_type cmd,
   output skct_pkg::stat_type stat,
   output logic              rsp_valid,
   output skct_pkg::rsp_type rsp_item
);
   import skct_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int UW = $clog2(TABLE_DEPTH + 1);
   localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

   logic [31:0] key_mem   [TABLE_DEPTH];
   logic [31:0] count_mem [TABLE_DEPTH];

   req_type       req_ff, req_in;
   logic [UW-1:0] lo_ff, lo_in;
   logic [UW-1:0] hi_ff, hi_in;
   logic [UW-1:0] mid_ff, mid_in;
   logic [UW-1:0] i_ff, i_in;
   logic [UW-1:0] used_ff, used_in;
   logic [31:0]   rd_key_ff;
   logic [31:0]   rd_count_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [UW:0]   mid_sum;
   logic [UW-1:0] i_dec;
   logic [32:0]   sum;
   logic [31:0]   sat_count;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0]   wr_key;
   logic [31:0]   wr_count;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign i_dec     = i_ff - UW'(1);
   assign sum       = {1'b0, rd_count_ff} + 33'(req_ff.increment);
   assign sat_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   always_comb begin
      stat.op         = req_ff.operation;
      stat.lo_lt_hi   = lo_ff < hi_ff;
      stat.key_lt     = req_ff.key < rd_key_ff;
      stat.key_eq     = req_ff.key == rd_key_ff;
      stat.table_full = used_ff == DEPTH_U;
      stat.shift_more = i_ff > lo_ff;
      stat.read_ok    = 32'(req_ff.index) < 32'(used_ff);
   end

   always_comb begin
      req_in  = req_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      mid_in  = mid_ff;
      i_in    = i_ff;
      used_in = used_ff;
      if (cmd.capture) begin
         req_in = req_item;
         lo_in  = '0;
         hi_in  = used_ff;
         i_in   = used_ff;
      end
      if (cmd.search_rd) begin
         mid_in = mid_sum[UW:1];
      end
      if (cmd.search_step) begin
         if (stat.key_lt) begin
            hi_in = mid_ff;
         end else begin
            lo_in = mid_ff + UW'(1);
         end
      end
      if (cmd.shift_wr) begin
         i_in = i_dec;
      end
      if (cmd.result == RES_INSERT) begin
         used_in = used_ff + UW'(1);
      end else if (cmd.result == RES_CLEAR) begin
         used_in = '0;
      end
   end

   // one read port shared by search, shift and read items
   always_comb begin
      rd_en   = cmd.search_rd | cmd.shift_rd | cmd.read_rd;
      rd_addr = IW'(req_ff.index);
      if (cmd.search_rd) begin
         rd_addr = mid_sum[IW:1];
      end else if (cmd.shift_rd) begin
         rd_addr = i_dec[IW-1:0];
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = i_ff[IW-1:0];
      wr_key   = rd_key_ff;
      wr_count = rd_count_ff;
      if (cmd.shift_wr) begin
         wr_en = 1'b1;
      end else if (cmd.result == RES_UPDATE) begin
         wr_en    = 1'b1;
         wr_addr  = mid_ff[IW-1:0];
         wr_count = sat_count;
      end else if (cmd.result == RES_INSERT) begin
         wr_en    = 1'b1;
         wr_addr  = lo_ff[IW-1:0];
         wr_key   = req_ff.key;
         wr_count = 32'(req_ff.increment);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         count_mem[wr_addr] <= wr_count;
      end
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_count_ff <= count_mem[rd_addr];
      end
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = STAT_OK;
      rsp_in.entries_used = 9'(used_in);
      rsp_valid_in        = cmd.result != RES_NONE;
      unique case (cmd.result)
         RES_UPDATE: begin
            rsp_in.position    = 8'(mid_ff);
            rsp_in.entry_key   = rd_key_ff;
            rsp_in.entry_count = sat_count;
         end
         RES_INSERT: begin
            rsp_in.position     = 8'(lo_ff);
            rsp_in.entry_key    = req_ff.key;
            rsp_in.entry_count  = 32'(req_ff.increment);
            rsp_in.was_inserted = 1'b1;
         end
         RES_READ: begin
            rsp_in.position    = req_ff.index;
            rsp_in.entry_key   = rd_key_ff;
            rsp_in.entry_count = rd_count_ff;
         end
         RES_FULL:  rsp_in.status = STAT_FULL;
         RES_RANGE: rsp_in.status = STAT_RANGE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      i_ff   <= i_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### src/skct_ctrl.sv
module skct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  skct_pkg::stat_type stat,
   output logic               busy,
   output skct_pkg::cmd_type  cmd
);
   import skct_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (start) state_in = ST_DECODE;
         ST_DECODE: begin
            if (stat.op == OP_ADD) begin
               state_in = ST_SEARCH;
            end else if (stat.op == OP_READ && stat.read_ok) begin
               state_in = ST_READ_DONE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            priority if (stat.lo_lt_hi) state_in = ST_COMPARE;
            else if (stat.table_full)   state_in = ST_IDLE;
            else                        state_in = ST_SHIFT_RD;
         end
         ST_COMPARE:   state_in = stat.key_eq ? ST_UPDATE : ST_SEARCH;
         ST_UPDATE:    state_in = ST_IDLE;
         ST_SHIFT_RD:  state_in = stat.shift_more ? ST_SHIFT_WR : ST_INSERT;
         ST_SHIFT_WR:  state_in = ST_SHIFT_RD;
         ST_INSERT:    state_in = ST_IDLE;
         ST_READ_DONE: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      cmd.result = RES_NONE;
      busy = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE:   cmd.capture = start;
         ST_DECODE: begin
            unique case (stat.op)
               OP_ADD:   ;
               OP_READ: begin
                  if (stat.read_ok) begin
                     cmd.read_rd = 1'b1;
                  end else begin
                     cmd.result = RES_RANGE;
                  end
               end
               OP_CLEAR: cmd.result = RES_CLEAR;
               default:  cmd.result = RES_NOP;
            endcase
         end
         ST_SEARCH: begin
            priority if (stat.lo_lt_hi) cmd.search_rd = 1'b1;
            else if (stat.table_full)   cmd.result = RES_FULL;
            else                        ;
         end
         ST_COMPARE:   cmd.search_step = !stat.key_eq;
         ST_UPDATE:    cmd.result = RES_UPDATE;
         ST_SHIFT_RD:  cmd.shift_rd = stat.shift_more;
         ST_SHIFT_WR:  cmd.shift_wr = 1'b1;
         ST_INSERT:    cmd.result = RES_INSERT;
         ST_READ_DONE: cmd.result = RES_READ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/sorted_key_count_table.sv
// channel   ports                    direction  handshake
// request   start, busy, req_item    in         taken when start && !busy
// response  rsp_valid, rsp_item      out        one-cycle strobe, no back-pressure
//
// one item at a time; busy stays high from acceptance until the response strobe
// read, clear: decode, then result; add of present key: search probes, then update
// add of a new key also moves entries up one by one (one read port), then inserts
// synchronous reset empties the table; no memory clearing pass is needed
module sorted_key_count_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  skct_pkg::req_type req_item,
   output logic              rsp_valid,
   output skct_pkg::rsp_type rsp_item
);
   import skct_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   skct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   skct_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
